FILE: design/ctsc_pkg.sv
// ----------------------------------------------------------------------------
// ctsc_pkg: shared types and constants of the C subset token scanner
// Token kinds, byte codes, keyword table and operator tables.
// ----------------------------------------------------------------------------
`default_nettype none

package ctsc_pkg;

  localparam int unsigned DEF_LINE_BITS   = 16;
  localparam int unsigned DEF_COLUMN_BITS = 16;
  localparam int unsigned DEF_LENGTH_BITS = 8;

  localparam int unsigned KIND_BITS = 6;
  localparam int unsigned NUM_RES   = 3;
  localparam int unsigned KW_COUNT  = 11;

  // token kinds
  localparam logic [KIND_BITS-1:0] KIND_END     = 6'd0;
  localparam logic [KIND_BITS-1:0] KIND_IDENT   = 6'd1;
  localparam logic [KIND_BITS-1:0] KIND_INT     = 6'd2;
  localparam logic [KIND_BITS-1:0] KIND_KW0     = 6'd3;
  localparam logic [KIND_BITS-1:0] KIND_PLUS    = 6'd14;
  localparam logic [KIND_BITS-1:0] KIND_MINUS   = 6'd15;
  localparam logic [KIND_BITS-1:0] KIND_STAR    = 6'd16;
  localparam logic [KIND_BITS-1:0] KIND_SLASH   = 6'd17;
  localparam logic [KIND_BITS-1:0] KIND_PERCENT = 6'd18;
  localparam logic [KIND_BITS-1:0] KIND_EQEQ    = 6'd19;
  localparam logic [KIND_BITS-1:0] KIND_NE      = 6'd20;
  localparam logic [KIND_BITS-1:0] KIND_LT      = 6'd21;
  localparam logic [KIND_BITS-1:0] KIND_LE      = 6'd22;
  localparam logic [KIND_BITS-1:0] KIND_GT      = 6'd23;
  localparam logic [KIND_BITS-1:0] KIND_GE      = 6'd24;
  localparam logic [KIND_BITS-1:0] KIND_ANDAND  = 6'd25;
  localparam logic [KIND_BITS-1:0] KIND_OROR    = 6'd26;
  localparam logic [KIND_BITS-1:0] KIND_BANG    = 6'd27;
  localparam logic [KIND_BITS-1:0] KIND_ASSIGN  = 6'd28;
  localparam logic [KIND_BITS-1:0] KIND_SEMI    = 6'd29;
  localparam logic [KIND_BITS-1:0] KIND_COMMA   = 6'd30;
  localparam logic [KIND_BITS-1:0] KIND_LPAREN  = 6'd31;
  localparam logic [KIND_BITS-1:0] KIND_RPAREN  = 6'd32;
  localparam logic [KIND_BITS-1:0] KIND_LBRACE  = 6'd33;
  localparam logic [KIND_BITS-1:0] KIND_RBRACE  = 6'd34;
  localparam logic [KIND_BITS-1:0] KIND_UNKNOWN = 6'd35;

  // byte codes
  localparam logic [7:0] CHAR_LF      = 8'h0A;
  localparam logic [7:0] CHAR_CR      = 8'h0D;
  localparam logic [7:0] CHAR_TAB     = 8'h09;
  localparam logic [7:0] CHAR_VT      = 8'h0B;
  localparam logic [7:0] CHAR_FF      = 8'h0C;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_HASH    = 8'h23;
  localparam logic [7:0] CHAR_UNDER   = 8'h5F;
  localparam logic [7:0] CHAR_EQ      = 8'h3D;
  localparam logic [7:0] CHAR_BANG    = 8'h21;
  localparam logic [7:0] CHAR_LT      = 8'h3C;
  localparam logic [7:0] CHAR_GT      = 8'h3E;
  localparam logic [7:0] CHAR_AMP     = 8'h26;
  localparam logic [7:0] CHAR_BAR     = 8'h7C;
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;
  localparam logic [7:0] CHAR_STAR    = 8'h2A;
  localparam logic [7:0] CHAR_PERCENT = 8'h25;
  localparam logic [7:0] CHAR_SEMI    = 8'h3B;
  localparam logic [7:0] CHAR_COMMA   = 8'h2C;
  localparam logic [7:0] CHAR_LPAREN  = 8'h28;
  localparam logic [7:0] CHAR_RPAREN  = 8'h29;
  localparam logic [7:0] CHAR_LBRACE  = 8'h7B;
  localparam logic [7:0] CHAR_RBRACE  = 8'h7D;

  // pending operator codes
  localparam logic [2:0] PEND_NONE  = 3'd0;
  localparam logic [2:0] PEND_EQ    = 3'd1;
  localparam logic [2:0] PEND_BANG  = 3'd2;
  localparam logic [2:0] PEND_LT    = 3'd3;
  localparam logic [2:0] PEND_GT    = 3'd4;
  localparam logic [2:0] PEND_AMP   = 3'd5;
  localparam logic [2:0] PEND_BAR   = 3'd6;
  localparam logic [2:0] PEND_SLASH = 3'd7;

  // keywords, in kind order starting at KIND_KW0
  localparam logic [7:0] KW_TEXT [KW_COUNT][8] = '{
    '{"i", "n", "t", "3", "2", "_", "t", 8'h00},
    '{"i", "n", "t", "6", "4", "_", "t", 8'h00},
    '{"b", "o", "o", "l", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"v", "o", "i", "d", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00},
    '{"t", "r", "u", "e", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"f", "a", "l", "s", "e", 8'h00, 8'h00, 8'h00},
    '{"f", "o", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00}
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd7, 4'd7, 4'd4, 4'd4, 4'd2, 4'd4, 4'd6, 4'd4, 4'd5, 4'd3, 4'd5
  };

  typedef struct packed {
    logic                 letter;
    logic                 digit;
    logic                 blank;
    logic                 lf;
    logic                 cr;
    logic                 hash;
    logic [2:0]           pend_code;
    logic [KIND_BITS-1:0] single_kind;
  } byte_class_t;

  // kind of a pending operator that stands alone
  function automatic logic [KIND_BITS-1:0] pend_single(input logic [2:0] code);
    logic [KIND_BITS-1:0] k;
    unique case (code)
      PEND_EQ:    k = KIND_ASSIGN;
      PEND_BANG:  k = KIND_BANG;
      PEND_LT:    k = KIND_LT;
      PEND_GT:    k = KIND_GT;
      PEND_SLASH: k = KIND_SLASH;
      default:    k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

  // kind of a pending operator joined with its second byte
  function automatic logic [KIND_BITS-1:0] pend_pair(input logic [2:0] code);
    logic [KIND_BITS-1:0] k;
    unique case (code)
      PEND_EQ:   k = KIND_EQEQ;
      PEND_BANG: k = KIND_NE;
      PEND_LT:   k = KIND_LE;
      PEND_GT:   k = KIND_GE;
      PEND_AMP:  k = KIND_ANDAND;
      PEND_BAR:  k = KIND_OROR;
      default:   k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

  // second byte that completes a pair with the pending operator
  function automatic logic pend_pairs(input logic [2:0] code, input logic [7:0] b);
    logic hit;
    case (code)
      PEND_EQ, PEND_BANG, PEND_LT, PEND_GT: hit = (b == CHAR_EQ);
      PEND_AMP: hit = (b == CHAR_AMP);
      PEND_BAR: hit = (b == CHAR_BAR);
      default:  hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

`default_nettype wire

FILE: design/ctsc_classify.sv
// ----------------------------------------------------------------------------
// ctsc_classify: byte classifier
// Sorts one source byte into letter, digit, blank, line break, hash,
// operator that may start a pair, or single-character token kind.
// ----------------------------------------------------------------------------
`default_nettype none

module ctsc_classify
  import ctsc_pkg::*;
(
  input  logic [7:0]  byte_i,
  output byte_class_t class_o
);

  always_comb begin
    class_o.letter = (byte_i == CHAR_UNDER) ||
                     (byte_i >= "A" && byte_i <= "Z") ||
                     (byte_i >= "a" && byte_i <= "z");
    class_o.digit  = (byte_i >= "0" && byte_i <= "9");
    class_o.blank  = (byte_i == CHAR_SPACE) || (byte_i == CHAR_TAB) ||
                     (byte_i == CHAR_FF) || (byte_i == CHAR_VT);
    class_o.lf     = (byte_i == CHAR_LF);
    class_o.cr     = (byte_i == CHAR_CR);
    class_o.hash   = (byte_i == CHAR_HASH);

    case (byte_i)
      CHAR_EQ:    class_o.pend_code = PEND_EQ;
      CHAR_BANG:  class_o.pend_code = PEND_BANG;
      CHAR_LT:    class_o.pend_code = PEND_LT;
      CHAR_GT:    class_o.pend_code = PEND_GT;
      CHAR_AMP:   class_o.pend_code = PEND_AMP;
      CHAR_BAR:   class_o.pend_code = PEND_BAR;
      CHAR_SLASH: class_o.pend_code = PEND_SLASH;
      default:    class_o.pend_code = PEND_NONE;
    endcase

    case (byte_i)
      CHAR_PLUS:    class_o.single_kind = KIND_PLUS;
      CHAR_MINUS:   class_o.single_kind = KIND_MINUS;
      CHAR_STAR:    class_o.single_kind = KIND_STAR;
      CHAR_PERCENT: class_o.single_kind = KIND_PERCENT;
      CHAR_SEMI:    class_o.single_kind = KIND_SEMI;
      CHAR_COMMA:   class_o.single_kind = KIND_COMMA;
      CHAR_LPAREN:  class_o.single_kind = KIND_LPAREN;
      CHAR_RPAREN:  class_o.single_kind = KIND_RPAREN;
      CHAR_LBRACE:  class_o.single_kind = KIND_LBRACE;
      CHAR_RBRACE:  class_o.single_kind = KIND_RBRACE;
      default:      class_o.single_kind = KIND_UNKNOWN;
    endcase
  end

endmodule

`default_nettype wire

FILE: design/ctsc_scan.sv
// ----------------------------------------------------------------------------
// ctsc_scan: scanner state and single-pass step logic
// Holds the scan state and, for the item in the input register, works out
// up to three tokens and the next state in one pass.
// ----------------------------------------------------------------------------
`default_nettype none

module ctsc_scan
  import ctsc_pkg::*;
#(
  parameter int unsigned LINE_BITS   = DEF_LINE_BITS,
  parameter int unsigned COLUMN_BITS = DEF_COLUMN_BITS,
  parameter int unsigned LENGTH_BITS = DEF_LENGTH_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   advance_i,
  input  logic [7:0]             byte_i,
  input  logic                   present_i,
  input  logic                   eot_i,
  input  byte_class_t            class_i,
  output logic [1:0]             res_count_o,
  output logic [KIND_BITS-1:0]   res_kind_o   [NUM_RES],
  output logic [LINE_BITS-1:0]   res_line_o   [NUM_RES],
  output logic [COLUMN_BITS-1:0] res_column_o [NUM_RES],
  output logic [LENGTH_BITS-1:0] res_length_o [NUM_RES]
);

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_WORD,
    MODE_NUMBER,
    MODE_COMMENT,
    MODE_PENDING
  } mode_e;

  localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);
  localparam logic [COLUMN_BITS-1:0] COL_ONE  = COLUMN_BITS'(1);
  localparam logic [LENGTH_BITS-1:0] LEN_ONE  = LENGTH_BITS'(1);
  localparam logic [LENGTH_BITS-1:0] LEN_TWO  = LENGTH_BITS'(2);

  mode_e                  mode_q, mode_d;
  logic [2:0]             pend_q, pend_d;
  logic                   cr_q, cr_d;
  logic [LINE_BITS-1:0]   line_q, line_d;
  logic [COLUMN_BITS-1:0] col_q, col_d;
  logic [LINE_BITS-1:0]   tok_line_q, tok_line_d;
  logic [COLUMN_BITS-1:0] tok_col_q, tok_col_d;
  logic [LENGTH_BITS-1:0] cnt_q, cnt_d;
  logic [KW_COUNT-1:0]    mask_q, mask_d;

  logic                   do_idle;
  logic [1:0]             n_v;

  function automatic logic [KW_COUNT-1:0] mask_after(input logic [KW_COUNT-1:0] mask,
                                                     input logic [LENGTH_BITS-1:0] pos,
                                                     input logic [7:0] b);
    logic [KW_COUNT-1:0] m;
    m = mask;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (pos >= LENGTH_BITS'(KW_LEN[k]) || KW_TEXT[k][pos[2:0]] != b) begin
        m[k] = 1'b0;
      end
    end
    return m;
  endfunction

  function automatic logic [KIND_BITS-1:0] close_kind(input logic word,
                                                      input logic [KW_COUNT-1:0] mask,
                                                      input logic [LENGTH_BITS-1:0] cnt);
    logic [KIND_BITS-1:0] kind;
    kind = word ? KIND_IDENT : KIND_INT;
    if (word) begin
      for (int k = 0; k < KW_COUNT; k++) begin
        if (mask[k] && cnt == LENGTH_BITS'(KW_LEN[k])) begin
          kind = KIND_KW0 + KIND_BITS'(k);
        end
      end
    end
    return kind;
  endfunction

  always_comb begin
    mode_d     = mode_q;
    pend_d     = pend_q;
    cr_d       = cr_q;
    line_d     = line_q;
    col_d      = col_q;
    tok_line_d = tok_line_q;
    tok_col_d  = tok_col_q;
    cnt_d      = cnt_q;
    mask_d     = mask_q;
    do_idle    = 1'b0;
    n_v        = 2'd0;
    for (int i = 0; i < NUM_RES; i++) begin
      res_kind_o[i]   = KIND_END;
      res_line_o[i]   = line_q;
      res_column_o[i] = col_q;
      res_length_o[i] = '0;
    end

    if (present_i) begin
      // LF right after CR belongs to the same line break
      if (!(cr_d && class_i.lf)) begin
        unique case (mode_q)
          MODE_WORD, MODE_NUMBER: begin
            if (class_i.digit || (mode_q == MODE_WORD && class_i.letter)) begin
              if (mode_q == MODE_WORD) begin
                mask_d = mask_after(mask_q, cnt_q, byte_i);
              end
              if (cnt_q != '1) cnt_d = cnt_q + LEN_ONE;
              if (col_d != '1) col_d = col_d + COL_ONE;
            end else begin
              res_kind_o[n_v]   = close_kind(mode_q == MODE_WORD, mask_q, cnt_q);
              res_line_o[n_v]   = tok_line_q;
              res_column_o[n_v] = tok_col_q;
              res_length_o[n_v] = cnt_q;
              n_v               = n_v + 2'd1;
              mode_d            = MODE_IDLE;
              do_idle           = 1'b1;
            end
          end
          MODE_COMMENT: begin
            if (class_i.lf || class_i.cr) begin
              mode_d  = MODE_IDLE;
              do_idle = 1'b1;
            end else if (col_d != '1) begin
              col_d = col_d + COL_ONE;
            end
          end
          MODE_PENDING: begin
            mode_d = MODE_IDLE;
            pend_d = PEND_NONE;
            if (pend_q == PEND_SLASH && byte_i == CHAR_SLASH) begin
              mode_d = MODE_COMMENT;
              if (col_d != '1) col_d = col_d + COL_ONE;
            end else if (pend_pairs(pend_q, byte_i)) begin
              res_kind_o[n_v]   = pend_pair(pend_q);
              res_line_o[n_v]   = tok_line_q;
              res_column_o[n_v] = tok_col_q;
              res_length_o[n_v] = LEN_TWO;
              n_v               = n_v + 2'd1;
              if (col_d != '1) col_d = col_d + COL_ONE;
            end else begin
              res_kind_o[n_v]   = pend_single(pend_q);
              res_line_o[n_v]   = tok_line_q;
              res_column_o[n_v] = tok_col_q;
              res_length_o[n_v] = LEN_ONE;
              n_v               = n_v + 2'd1;
              do_idle           = 1'b1;
            end
          end
          default: begin
            mode_d  = MODE_IDLE;
            do_idle = 1'b1;
          end
        endcase
      end
      cr_d = 1'b0;

      if (do_idle) begin
        if (class_i.lf || class_i.cr) begin
          if (line_d != '1) line_d = line_d + LINE_ONE;
          col_d = COL_ONE;
          cr_d  = class_i.cr;
        end else if (class_i.blank) begin
          if (col_d != '1) col_d = col_d + COL_ONE;
        end else if (class_i.hash) begin
          mode_d = MODE_COMMENT;
          if (col_d != '1) col_d = col_d + COL_ONE;
        end else if (class_i.letter || class_i.digit || class_i.pend_code != PEND_NONE) begin
          if (class_i.letter) begin
            mode_d = MODE_WORD;
            mask_d = mask_after('1, '0, byte_i);
          end else if (class_i.digit) begin
            mode_d = MODE_NUMBER;
          end else begin
            mode_d = MODE_PENDING;
            pend_d = class_i.pend_code;
          end
          tok_line_d = line_d;
          tok_col_d  = col_d;
          cnt_d      = LEN_ONE;
          if (col_d != '1) col_d = col_d + COL_ONE;
        end else begin
          res_kind_o[n_v]   = class_i.single_kind;
          res_line_o[n_v]   = line_d;
          res_column_o[n_v] = col_d;
          res_length_o[n_v] = LEN_ONE;
          n_v               = n_v + 2'd1;
          if (col_d != '1) col_d = col_d + COL_ONE;
        end
      end
    end

    if (eot_i) begin
      if (mode_d == MODE_WORD || mode_d == MODE_NUMBER) begin
        res_kind_o[n_v]   = close_kind(mode_d == MODE_WORD, mask_d, cnt_d);
        res_line_o[n_v]   = tok_line_d;
        res_column_o[n_v] = tok_col_d;
        res_length_o[n_v] = cnt_d;
        n_v               = n_v + 2'd1;
      end else if (mode_d == MODE_PENDING) begin
        res_kind_o[n_v]   = pend_single(pend_d);
        res_line_o[n_v]   = tok_line_d;
        res_column_o[n_v] = tok_col_d;
        res_length_o[n_v] = LEN_ONE;
        n_v               = n_v + 2'd1;
      end
      res_kind_o[n_v]   = KIND_END;
      res_line_o[n_v]   = line_d;
      res_column_o[n_v] = col_d;
      res_length_o[n_v] = '0;
      n_v               = n_v + 2'd1;
      // back to the reset state for the next text
      mode_d     = MODE_IDLE;
      pend_d     = PEND_NONE;
      cr_d       = 1'b0;
      line_d     = LINE_ONE;
      col_d      = COL_ONE;
      tok_line_d = LINE_ONE;
      tok_col_d  = COL_ONE;
      cnt_d      = '0;
      mask_d     = '1;
    end

    res_count_o = n_v;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_IDLE;
      pend_q     <= PEND_NONE;
      cr_q       <= 1'b0;
      line_q     <= LINE_ONE;
      col_q      <= COL_ONE;
      tok_line_q <= LINE_ONE;
      tok_col_q  <= COL_ONE;
      cnt_q      <= '0;
      mask_q     <= '1;
    end else if (advance_i) begin
      mode_q     <= mode_d;
      pend_q     <= pend_d;
      cr_q       <= cr_d;
      line_q     <= line_d;
      col_q      <= col_d;
      tok_line_q <= tok_line_d;
      tok_col_q  <= tok_col_d;
      cnt_q      <= cnt_d;
      mask_q     <= mask_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/ctsc_out_buf.sv
// ----------------------------------------------------------------------------
// ctsc_out_buf: result register
// Holds the tokens of one item and hands them out one per transaction,
// marking the final one. Takes the next item's tokens as the last leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module ctsc_out_buf
  import ctsc_pkg::*;
#(
  parameter int unsigned LINE_BITS   = DEF_LINE_BITS,
  parameter int unsigned COLUMN_BITS = DEF_COLUMN_BITS,
  parameter int unsigned LENGTH_BITS = DEF_LENGTH_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  logic [1:0]             load_count_i,
  input  logic [KIND_BITS-1:0]   load_kind_i   [NUM_RES],
  input  logic [LINE_BITS-1:0]   load_line_i   [NUM_RES],
  input  logic [COLUMN_BITS-1:0] load_column_i [NUM_RES],
  input  logic [LENGTH_BITS-1:0] load_length_i [NUM_RES],
  output logic                   can_load_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [KIND_BITS-1:0]   token_kind_o,
  output logic [LINE_BITS-1:0]   start_line_o,
  output logic [COLUMN_BITS-1:0] start_column_o,
  output logic [LENGTH_BITS-1:0] token_length_o,
  output logic                   last_of_run_o
);

  logic [1:0]             cnt_q;
  logic [KIND_BITS-1:0]   kind_q   [NUM_RES];
  logic [LINE_BITS-1:0]   line_q   [NUM_RES];
  logic [COLUMN_BITS-1:0] column_q [NUM_RES];
  logic [LENGTH_BITS-1:0] length_q [NUM_RES];
  logic                   pop;

  assign pop        = out_valid_o && out_ready_i;
  assign can_load_o = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_ready_i);

  assign out_valid_o    = (cnt_q != 2'd0);
  assign last_of_run_o  = (cnt_q == 2'd1);
  assign token_kind_o   = kind_q[0];
  assign start_line_o   = line_q[0];
  assign start_column_o = column_q[0];
  assign token_length_o = length_q[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (load_i) begin
      cnt_q <= load_count_i;
    end else if (pop) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      kind_q   <= load_kind_i;
      line_q   <= load_line_i;
      column_q <= load_column_i;
      length_q <= load_length_i;
    end else if (pop) begin
      // slide the remaining tokens toward the port
      for (int i = 0; i < NUM_RES - 1; i++) begin
        kind_q[i]   <= kind_q[i+1];
        line_q[i]   <= line_q[i+1];
        column_q[i] <= column_q[i+1];
        length_q[i] <= length_q[i+1];
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/c_subset_token_scanner_core.sv
// ----------------------------------------------------------------------------
// c_subset_token_scanner_core: streaming token scanner for a small C subset
// Takes source text a byte per transaction and reports tokens with their
// kind, start line and column, and length.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o): one byte per transaction, with
//   byte_present_i low for a bare flush and end_of_text_i high on the last
//   item of a text. The end token follows and the scanner starts over.
//   Output channel (out_valid_o / out_ready_i): one token per transaction;
//   an item yields zero to three tokens, last_of_run_o marks its last.
//   The first token of an item is offered once the item has moved from the
//   input register into the result register.
//   The scanner takes one item per cycle while each yields at most one token
//   and the receiver is ready; after an item with several tokens, the next
//   item waits in the input register while the result register drains one
//   token per cycle while the receiver is ready. Items that yield no token
//   pass through even while the result register is stalled.
//   When the receiver stalls, the result register holds its tokens, the
//   input register fills, and in_ready_o drops.
//   Reset puts the scanner at line 1, column 1, between tokens, with both
//   registers empty.
// ----------------------------------------------------------------------------
`default_nettype none

module c_subset_token_scanner_core
  import ctsc_pkg::*;
#(
  parameter int unsigned LINE_BITS   = DEF_LINE_BITS,
  parameter int unsigned COLUMN_BITS = DEF_COLUMN_BITS,
  parameter int unsigned LENGTH_BITS = DEF_LENGTH_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [7:0]             text_byte_i,
  input  logic                   byte_present_i,
  input  logic                   end_of_text_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [KIND_BITS-1:0]   token_kind_o,
  output logic [LINE_BITS-1:0]   start_line_o,
  output logic [COLUMN_BITS-1:0] start_column_o,
  output logic [LENGTH_BITS-1:0] token_length_o,
  output logic                   last_of_run_o
);

  logic        in_valid_q;
  logic [7:0]  byte_q;
  logic        present_q;
  logic        eot_q;
  logic        take;
  logic        can_load;
  byte_class_t byte_class;

  logic [1:0]             res_count;
  logic [KIND_BITS-1:0]   res_kind   [NUM_RES];
  logic [LINE_BITS-1:0]   res_line   [NUM_RES];
  logic [COLUMN_BITS-1:0] res_column [NUM_RES];
  logic [LENGTH_BITS-1:0] res_length [NUM_RES];

  assign take       = in_valid_q && (res_count == 2'd0 || can_load);
  assign in_ready_o = !in_valid_q || take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q    <= text_byte_i;
      present_q <= byte_present_i;
      eot_q     <= end_of_text_i;
    end
  end

  ctsc_classify u_classify (
    .byte_i  (byte_q),
    .class_o (byte_class)
  );

  ctsc_scan #(
    .LINE_BITS   (LINE_BITS),
    .COLUMN_BITS (COLUMN_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .advance_i    (take),
    .byte_i       (byte_q),
    .present_i    (present_q),
    .eot_i        (eot_q),
    .class_i      (byte_class),
    .res_count_o  (res_count),
    .res_kind_o   (res_kind),
    .res_line_o   (res_line),
    .res_column_o (res_column),
    .res_length_o (res_length)
  );

  ctsc_out_buf #(
    .LINE_BITS   (LINE_BITS),
    .COLUMN_BITS (COLUMN_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_out_buf (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (take && res_count != 2'd0),
    .load_count_i   (res_count),
    .load_kind_i    (res_kind),
    .load_line_i    (res_line),
    .load_column_i  (res_column),
    .load_length_i  (res_length),
    .can_load_o     (can_load),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .token_kind_o   (token_kind_o),
    .start_line_o   (start_line_o),
    .start_column_o (start_column_o),
    .token_length_o (token_length_o),
    .last_of_run_o  (last_of_run_o)
  );

endmodule

`default_nettype wire
